### design/ntps_pkg.sv
`default_nettype none

package ntps_pkg;

   localparam int KEEP_COUNT_DEF = 3;
   localparam int COORD_BITS_DEF = 16;

   localparam int ID_W         = 32;
   localparam int PORT_COORD_W = 16;
   localparam int KIND_W       = 3;
   localparam int DIST_W       = 33;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUERY_X     = 2'd0,
      CSR_QUERY_Y     = 2'd1,
      CSR_FILTER_ON   = 2'd2,
      CSR_WANTED_TYPE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic fire;
      logic match;
      logic last;
   } slot_cmd_type;

endpackage

`default_nettype wire

### design/nearest_three_points_select_unit.sv
`default_nettype none
// After a query's last word is accepted, its results pass the delta, distance, batch
// and result-queue registers in that order, then leave one word per cycle while rsp_ready is high.
// Throughput: one input word per cycle; a query-ending word waits in the update stage
// only while the batch register is full and the result queue cannot take it yet.
// Reset: synchronous, active high; clears config registers, slot fill and all valids.
module nearest_three_points_select_unit #(
   parameter int KEEP_COUNT = ntps_pkg::KEEP_COUNT_DEF,
   parameter int COORD_BITS = ntps_pkg::COORD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [ntps_pkg::ID_W-1:0]         req_place_id,
   input  wire logic signed [ntps_pkg::PORT_COORD_W-1:0] req_place_x,
   input  wire logic signed [ntps_pkg::PORT_COORD_W-1:0] req_place_y,
   input  wire logic        [ntps_pkg::KIND_W-1:0]       req_place_kind,
   input  wire logic                                 req_last_place,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic             [ntps_pkg::ID_W-1:0]         rsp_near_id,
   output logic             [ntps_pkg::DIST_W-1:0]       rsp_near_distance,
   output logic                                      rsp_none_found,
   output logic                                      rsp_last_result,
   input  wire logic                                 csr_write_enable,
   input  wire logic        [ntps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic        [ntps_pkg::CSR_DATA_W-1:0]   csr_write_data
);
   import ntps_pkg::*;

   localparam int DW    = 2 * COORD_BITS + 1;
   localparam int IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
   localparam int CNT_W = $clog2(KEEP_COUNT + 1);

   // config registers
   logic [PORT_COORD_W-1:0] query_x_ff, query_y_ff;
   logic                    filter_on_ff;
   logic [KIND_W-1:0]       wanted_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff     <= '0;
         query_y_ff     <= '0;
         filter_on_ff   <= 1'b0;
         wanted_type_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUERY_X:     query_x_ff     <= csr_write_data[PORT_COORD_W-1:0];
            CSR_QUERY_Y:     query_y_ff     <= csr_write_data[PORT_COORD_W-1:0];
            CSR_FILTER_ON:   filter_on_ff   <= csr_write_data[0];
            CSR_WANTED_TYPE: wanted_type_ff <= csr_write_data[KIND_W-1:0];
         endcase
      end
   end

   // coordinate deltas on the incoming word
   logic        [COORD_BITS-1:0] px_c, py_c, qx_c, qy_c;
   logic signed [COORD_BITS:0]   px_e, py_e, qx_e, qy_e, dx_s, dy_s;
   logic        [COORD_BITS-1:0] dx_abs, dy_abs;
   logic                         kind_match;

   always_comb begin
      px_c   = COORD_BITS'($unsigned(req_place_x));
      py_c   = COORD_BITS'($unsigned(req_place_y));
      qx_c   = COORD_BITS'(query_x_ff);
      qy_c   = COORD_BITS'(query_y_ff);
      px_e   = {px_c[COORD_BITS-1], px_c};
      py_e   = {py_c[COORD_BITS-1], py_c};
      qx_e   = {qx_c[COORD_BITS-1], qx_c};
      qy_e   = {qy_c[COORD_BITS-1], qy_c};
      dx_s   = px_e - qx_e;
      dy_s   = py_e - qy_e;
      dx_abs = dx_s[COORD_BITS] ? COORD_BITS'(-dx_s) : dx_s[COORD_BITS-1:0];
      dy_abs = dy_s[COORD_BITS] ? COORD_BITS'(-dy_s) : dy_s[COORD_BITS-1:0];
      kind_match = !filter_on_ff || (req_place_kind == wanted_type_ff);
   end

   // pipeline control
   logic s1_valid_ff, s2_valid_ff, batch_valid_ff, q_valid_ff;
   logic s2_last_ff, s2_match_ff;
   logic s2_fire, s2_open, s1_move, req_fire, rsp_fire, q_at_last, q_free, batch_move;

   // a query-ending word may fire while the held batch moves into the queue
   assign s2_fire   = s2_valid_ff && (!s2_last_ff || !batch_valid_ff || batch_move);
   assign s2_open   = !s2_valid_ff || s2_fire;
   assign req_ready = !s1_valid_ff || s2_open;
   assign req_fire  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && s2_open;

   // stage 1: deltas
   logic [ID_W-1:0]       s1_id_ff;
   logic [COORD_BITS-1:0] s1_dx_ff, s1_dy_ff;
   logic                  s1_match_ff, s1_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_id_ff    <= req_place_id;
         s1_dx_ff    <= dx_abs;
         s1_dy_ff    <= dy_abs;
         s1_match_ff <= kind_match;
         s1_last_ff  <= req_last_place;
      end
   end

   // stage 2: squared distance
   logic [2*COORD_BITS-1:0] sq_x, sq_y;
   logic [DW-1:0]           dist_in;
   logic [ID_W-1:0]         s2_id_ff;
   logic [DW-1:0]           s2_dist_ff;

   assign sq_x    = s1_dx_ff * s1_dx_ff;
   assign sq_y    = s1_dy_ff * s1_dy_ff;
   assign dist_in = DW'(sq_x) + DW'(sq_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_open) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_id_ff    <= s1_id_ff;
         s2_dist_ff  <= dist_in;
         s2_match_ff <= s1_match_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // slot update
   slot_cmd_type     slot_cmd;
   logic [ID_W-1:0]  snap_ids  [KEEP_COUNT];
   logic [DW-1:0]    snap_dist [KEEP_COUNT];
   logic [CNT_W-1:0] snap_count;

   assign slot_cmd = '{fire: s2_fire, match: s2_match_ff, last: s2_last_ff};

   ntps_slot_keeper #(
      .KEEP_COUNT (KEEP_COUNT),
      .DW         (DW),
      .CNT_W      (CNT_W)
   ) u_keeper (
      .clock      (clock),
      .reset      (reset),
      .cmd        (slot_cmd),
      .new_id     (s2_id_ff),
      .new_dist   (s2_dist_ff),
      .snap_ids   (snap_ids),
      .snap_dist  (snap_dist),
      .snap_count (snap_count)
   );

   // batch register: kept slots of a finished query
   logic [ID_W-1:0]  batch_ids_ff  [KEEP_COUNT];
   logic [DW-1:0]    batch_dist_ff [KEEP_COUNT];
   logic [CNT_W-1:0] batch_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_valid_ff <= 1'b0;
      end else if (s2_fire && s2_last_ff) begin
         batch_valid_ff <= 1'b1;
      end else if (batch_move) begin
         batch_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire && s2_last_ff) begin
         batch_ids_ff   <= snap_ids;
         batch_dist_ff  <= snap_dist;
         batch_count_ff <= snap_count;
      end
   end

   logic [ID_W-1:0] sorted_ids  [KEEP_COUNT];
   logic [DW-1:0]   sorted_dist [KEEP_COUNT];

   ntps_sorter #(
      .KEEP_COUNT (KEEP_COUNT),
      .DW         (DW),
      .CNT_W      (CNT_W)
   ) u_sorter (
      .in_ids   (batch_ids_ff),
      .in_dist  (batch_dist_ff),
      .in_count (batch_count_ff),
      .out_ids  (sorted_ids),
      .out_dist (sorted_dist)
   );

   // result queue, drained one word per cycle while rsp_ready is high
   logic [ID_W-1:0]  q_ids_ff  [KEEP_COUNT];
   logic [DW-1:0]    q_dist_ff [KEEP_COUNT];
   logic [CNT_W-1:0] q_count_ff;
   logic [IDX_W-1:0] q_ptr_ff;
   logic             q_none_ff;

   assign rsp_fire   = q_valid_ff && rsp_ready;
   assign q_at_last  = (CNT_W'(q_ptr_ff) + 1'b1) == q_count_ff;
   assign q_free     = !q_valid_ff || (rsp_fire && q_at_last);
   assign batch_move = batch_valid_ff && q_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
         q_ptr_ff   <= '0;
      end else if (batch_move) begin
         q_valid_ff <= 1'b1;
         q_ptr_ff   <= '0;
      end else if (rsp_fire) begin
         if (q_at_last) begin
            q_valid_ff <= 1'b0;
         end else begin
            q_ptr_ff <= q_ptr_ff + 1'b1;
         end
      end
   end

   // empty query: one word, zero fields (sorter gives zeros for count zero)
   always_ff @(posedge clock) begin
      if (batch_move) begin
         q_ids_ff   <= sorted_ids;
         q_dist_ff  <= sorted_dist;
         q_none_ff  <= (batch_count_ff == '0);
         q_count_ff <= (batch_count_ff == '0) ? CNT_W'(1) : batch_count_ff;
      end
   end

   assign rsp_valid         = q_valid_ff;
   assign rsp_near_id       = q_ids_ff[q_ptr_ff];
   assign rsp_near_distance = DIST_W'(q_dist_ff[q_ptr_ff]);
   assign rsp_none_found    = q_none_ff;
   assign rsp_last_result   = q_at_last;

endmodule

`default_nettype wire

### design/ntps_slot_keeper.sv
`default_nettype none

module ntps_slot_keeper #(
   parameter int KEEP_COUNT = ntps_pkg::KEEP_COUNT_DEF,
   parameter int DW         = 2 * ntps_pkg::COORD_BITS_DEF + 1,
   parameter int CNT_W      = $clog2(KEEP_COUNT + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ntps_pkg::slot_cmd_type     cmd,
   input  wire logic [ntps_pkg::ID_W-1:0]  new_id,
   input  wire logic [DW-1:0]              new_dist,
   output logic      [ntps_pkg::ID_W-1:0]  snap_ids   [KEEP_COUNT],
   output logic      [DW-1:0]              snap_dist  [KEEP_COUNT],
   output logic      [CNT_W-1:0]           snap_count
);
   import ntps_pkg::*;

   localparam int IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;

   logic [ID_W-1:0]  slot_ids_ff   [KEEP_COUNT];
   logic [DW-1:0]    slot_dist_ff  [KEEP_COUNT];
   logic [ID_W-1:0]  slot_ids_in   [KEEP_COUNT];
   logic [DW-1:0]    slot_dist_in  [KEEP_COUNT];
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] worst_ff, worst_in;
   logic [DW-1:0]    worst_dist_ff, worst_dist_in;

   always_comb begin
      slot_ids_in   = slot_ids_ff;
      slot_dist_in  = slot_dist_ff;
      fill_in       = fill_ff;
      worst_in      = worst_ff;
      worst_dist_in = worst_dist_ff;
      if (cmd.match) begin
         if (fill_ff < CNT_W'(KEEP_COUNT)) begin
            for (int i = 0; i < KEEP_COUNT; i++) begin
               if (fill_ff == CNT_W'(i)) begin
                  slot_ids_in[i]  = new_id;
                  slot_dist_in[i] = new_dist;
               end
            end
            // first word seeds the worst slot; later ones take it only when larger
            if (fill_ff == '0) begin
               worst_in      = '0;
               worst_dist_in = new_dist;
            end else if (worst_dist_ff < new_dist) begin
               worst_in      = fill_ff[IDX_W-1:0];
               worst_dist_in = new_dist;
            end
            fill_in = fill_ff + 1'b1;
         end else begin
            if (worst_dist_ff > new_dist) begin
               for (int i = 0; i < KEEP_COUNT; i++) begin
                  if (worst_ff == IDX_W'(i)) begin
                     slot_ids_in[i]  = new_id;
                     slot_dist_in[i] = new_dist;
                  end
               end
               worst_dist_in = new_dist;
            end
            // rescan from the current worst slot, moving only on strictly larger
            for (int i = 0; i < KEEP_COUNT; i++) begin
               if (slot_dist_in[i] > worst_dist_in) begin
                  worst_in      = IDX_W'(i);
                  worst_dist_in = slot_dist_in[i];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fire) begin
         slot_ids_ff   <= slot_ids_in;
         slot_dist_ff  <= slot_dist_in;
         worst_dist_ff <= worst_dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         worst_ff <= '0;
      end else if (cmd.fire) begin
         if (cmd.last) begin
            fill_ff  <= '0;
            worst_ff <= '0;
         end else begin
            fill_ff  <= fill_in;
            worst_ff <= worst_in;
         end
      end
   end

   assign snap_ids   = slot_ids_in;
   assign snap_dist  = slot_dist_in;
   assign snap_count = fill_in;

endmodule

`default_nettype wire

### design/ntps_sorter.sv
`default_nettype none

module ntps_sorter #(
   parameter int KEEP_COUNT = ntps_pkg::KEEP_COUNT_DEF,
   parameter int DW         = 2 * ntps_pkg::COORD_BITS_DEF + 1,
   parameter int CNT_W      = $clog2(KEEP_COUNT + 1)
) (
   input  wire logic [ntps_pkg::ID_W-1:0] in_ids   [KEEP_COUNT],
   input  wire logic [DW-1:0]             in_dist  [KEEP_COUNT],
   input  wire logic [CNT_W-1:0]          in_count,
   output logic      [ntps_pkg::ID_W-1:0] out_ids  [KEEP_COUNT],
   output logic      [DW-1:0]             out_dist [KEEP_COUNT]
);
   import ntps_pkg::*;

   logic [CNT_W-1:0] rank [KEEP_COUNT];

   // stable rank: smaller distances first, equal ones in slot order
   always_comb begin
      for (int i = 0; i < KEEP_COUNT; i++) begin
         rank[i] = '0;
         for (int j = 0; j < KEEP_COUNT; j++) begin
            if (CNT_W'(j) < in_count && j != i &&
                (in_dist[j] < in_dist[i] || (in_dist[j] == in_dist[i] && j < i))) begin
               rank[i] = rank[i] + 1'b1;
            end
         end
      end
   end

   always_comb begin
      for (int e = 0; e < KEEP_COUNT; e++) begin
         out_ids[e]  = '0;
         out_dist[e] = '0;
         for (int i = 0; i < KEEP_COUNT; i++) begin
            if (CNT_W'(i) < in_count && rank[i] == CNT_W'(e)) begin
               out_ids[e]  = in_ids[i];
               out_dist[e] = in_dist[i];
            end
         end
      end
   end

endmodule

`default_nettype wire

### sim/nearest_three_points_select_checker.sv
`default_nettype none

module nearest_three_points_select_checker (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   input  wire logic                                     req_ready,
   input  wire logic        [ntps_pkg::ID_W-1:0]         req_place_id,
   input  wire logic signed [ntps_pkg::PORT_COORD_W-1:0] req_place_x,
   input  wire logic signed [ntps_pkg::PORT_COORD_W-1:0] req_place_y,
   input  wire logic        [ntps_pkg::KIND_W-1:0]       req_place_kind,
   input  wire logic                                     req_last_place,
   input  wire logic                                     rsp_valid,
   input  wire logic                                     rsp_ready,
   input  wire logic        [ntps_pkg::ID_W-1:0]         rsp_near_id,
   input  wire logic        [ntps_pkg::DIST_W-1:0]       rsp_near_distance,
   input  wire logic                                     rsp_none_found,
   input  wire logic                                     rsp_last_result,
   input  wire logic                                     csr_write_enable,
   input  wire logic        [ntps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic        [ntps_pkg::CSR_DATA_W-1:0]   csr_write_data,
   output int                                            mismatch_count,
   output int                                            pending_words
);

   localparam int KEEP      = ntps_pkg::KEEP_COUNT_DEF;
   localparam int EXP_DEPTH = 64;

   typedef struct packed {
      logic [ntps_pkg::ID_W-1:0]   id;
      logic [ntps_pkg::DIST_W-1:0] sq_dist;
      logic                        none;
      logic                        last;
   } neighbor_word_type;

   // circular store of predicted words
   neighbor_word_type expected_words [EXP_DEPTH];
   int                exp_head;
   int                exp_count;

   logic signed [ntps_pkg::PORT_COORD_W-1:0] query_x_q;
   logic signed [ntps_pkg::PORT_COORD_W-1:0] query_y_q;
   logic                                     filter_on_q;
   logic        [ntps_pkg::KIND_W-1:0]       wanted_type_q;

   logic [ntps_pkg::ID_W-1:0] kept_id   [KEEP];
   logic [33:0]               kept_dist [KEEP];
   int                        kept_count;
   int                        worst_idx;

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic enqueue_expected(input neighbor_word_type w);
      if (exp_count == EXP_DEPTH) begin
         flag_mismatch("too many predicted words outstanding");
      end else begin
         expected_words[(exp_head + exp_count) % EXP_DEPTH] = w;
         exp_count++;
      end
   endtask

   function automatic logic [33:0] squared_distance(
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] px,
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] py
   );
      longint dx;
      longint dy;
      dx = longint'(px) - longint'(query_x_q);
      dy = longint'(py) - longint'(query_y_q);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      return 34'(dx * dx + dy * dy);
   endfunction

   task automatic absorb_place(
      input logic        [ntps_pkg::ID_W-1:0]         id,
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] px,
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] py,
      input logic        [ntps_pkg::KIND_W-1:0]       kind,
      input logic                                     last
   );
      logic [33:0]       d;
      int                order [KEEP];
      int                i;
      int                j;
      neighbor_word_type w;
      if (!filter_on_q || kind == wanted_type_q) begin
         d = squared_distance(px, py);
         if (kept_count < KEEP) begin
            kept_id[kept_count]   = id;
            kept_dist[kept_count] = d;
            if (kept_dist[worst_idx] < d) worst_idx = kept_count;
            kept_count++;
         end else begin
            if (kept_dist[worst_idx] > d) begin
               kept_id[worst_idx]   = id;
               kept_dist[worst_idx] = d;
            end
            // rescan starts from the current worst, moves only on strictly larger
            for (i = 0; i < KEEP; i++)
               if (kept_dist[i] > kept_dist[worst_idx]) worst_idx = i;
         end
      end
      if (!last) return;
      if (kept_count == 0) begin
         w = '{id: '0, sq_dist: '0, none: 1'b1, last: 1'b1};
         enqueue_expected(w);
      end else begin
         // stable sort: equal distances stay in slot order
         for (i = 0; i < kept_count; i++) begin
            j = i;
            while (j > 0 && kept_dist[order[j-1]] > kept_dist[i]) begin
               order[j] = order[j-1];
               j--;
            end
            order[j] = i;
         end
         for (i = 0; i < kept_count; i++) begin
            w.id      = kept_id[order[i]];
            w.sq_dist = kept_dist[order[i]][ntps_pkg::DIST_W-1:0];
            w.none    = 1'b0;
            w.last    = (i == kept_count - 1);
            enqueue_expected(w);
         end
      end
      kept_count = 0;
      worst_idx  = 0;
   endtask

   task automatic check_word();
      neighbor_word_type got;
      neighbor_word_type want;
      got = '{id: rsp_near_id, sq_dist: rsp_near_distance, none: rsp_none_found,
              last: rsp_last_result};
      if (exp_count == 0) begin
         flag_mismatch($sformatf("unexpected word id=%h dist=%0d none=%b last=%b",
                                 got.id, got.sq_dist, got.none, got.last));
      end else begin
         want      = expected_words[exp_head];
         exp_head  = (exp_head + 1) % EXP_DEPTH;
         exp_count--;
         if (got !== want)
            flag_mismatch($sformatf(
               "got id=%h dist=%0d none=%b last=%b, want id=%h dist=%0d none=%b last=%b",
               got.id, got.sq_dist, got.none, got.last,
               want.id, want.sq_dist, want.none, want.last));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         query_x_q      = '0;
         query_y_q      = '0;
         filter_on_q    = 1'b0;
         wanted_type_q  = '0;
         kept_count     = 0;
         worst_idx      = 0;
         mismatch_count = 0;
         for (int k = 0; k < KEEP; k++) begin
            kept_id[k]   = '0;
            kept_dist[k] = '0;
         end
         exp_head  = 0;
         exp_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_word();
         if (req_valid && req_ready)
            absorb_place(req_place_id, req_place_x, req_place_y, req_place_kind,
                         req_last_place);
         if (csr_write_enable) begin
            case (ntps_pkg::csr_index_type'(csr_index))
               ntps_pkg::CSR_QUERY_X:     query_x_q     = csr_write_data;
               ntps_pkg::CSR_QUERY_Y:     query_y_q     = csr_write_data;
               ntps_pkg::CSR_FILTER_ON:   filter_on_q   = csr_write_data[0];
               ntps_pkg::CSR_WANTED_TYPE: wanted_type_q = csr_write_data[2:0];
               default: ;
            endcase
         end
      end
      pending_words <= exp_count;
   end

endmodule

`default_nettype wire

### sim/nearest_three_points_select_unit_tb.sv
`default_nettype none

module nearest_three_points_select_unit_tb;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int QUIET_LIMIT     = 4000;
   localparam int SETTLE_CYCLES   = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                     req_valid      = 1'b0;
   logic                                     req_ready;
   logic        [ntps_pkg::ID_W-1:0]         req_place_id   = '0;
   logic signed [ntps_pkg::PORT_COORD_W-1:0] req_place_x    = '0;
   logic signed [ntps_pkg::PORT_COORD_W-1:0] req_place_y    = '0;
   logic        [ntps_pkg::KIND_W-1:0]       req_place_kind = '0;
   logic                                     req_last_place = 1'b0;
   logic                                     rsp_valid;
   logic                                     rsp_ready      = 1'b0;
   logic        [ntps_pkg::ID_W-1:0]         rsp_near_id;
   logic        [ntps_pkg::DIST_W-1:0]       rsp_near_distance;
   logic                                     rsp_none_found;
   logic                                     rsp_last_result;
   logic                                     csr_write_enable = 1'b0;
   logic        [ntps_pkg::CSR_IDX_W-1:0]    csr_index        = '0;
   logic        [ntps_pkg::CSR_DATA_W-1:0]   csr_write_data   = '0;

   int mismatch_count;
   int pending_words;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;

   logic signed [ntps_pkg::PORT_COORD_W-1:0] cur_qx     = '0;
   logic signed [ntps_pkg::PORT_COORD_W-1:0] cur_qy     = '0;
   logic                                     cur_filter = 1'b0;
   logic        [ntps_pkg::KIND_W-1:0]       cur_kind   = '0;

   int points_used   = 0;
   int places_sent   = 0;
   int queries_sent  = 0;
   int words_seen    = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;

   always #2 clock = ~clock;

   nearest_three_points_select_unit dut (.*);

   nearest_three_points_select_checker chk (.*);

   // receiver: random ready, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && !reset) words_seen++;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic offer_place(
      input logic        [ntps_pkg::ID_W-1:0]         id,
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] px,
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] py,
      input logic        [ntps_pkg::KIND_W-1:0]       kind,
      input logic                                     last
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_place_id   <= id;
      req_place_x    <= px;
      req_place_y    <= py;
      req_place_kind <= kind;
      req_last_place <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      places_sent++;
      if (!cur_filter || kind == cur_kind) points_used++;
      if (last) queries_sent++;
   endtask

   task automatic program_query(
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] qx,
      input logic signed [ntps_pkg::PORT_COORD_W-1:0] qy,
      input logic                                     filt,
      input logic        [ntps_pkg::KIND_W-1:0]       kind
   );
      logic [ntps_pkg::CSR_DATA_W-1:0] noisy;
      csr_write_enable <= 1'b1;
      csr_index        <= ntps_pkg::CSR_QUERY_X;
      csr_write_data   <= qx;
      @(negedge clock);
      csr_index        <= ntps_pkg::CSR_QUERY_Y;
      csr_write_data   <= qy;
      @(negedge clock);
      // upper bits of the narrow registers carry junk; the block must drop it
      noisy            = 16'($urandom);
      noisy[0]         = filt;
      csr_index        <= ntps_pkg::CSR_FILTER_ON;
      csr_write_data   <= noisy;
      @(negedge clock);
      noisy            = 16'($urandom);
      noisy[2:0]       = kind;
      csr_index        <= ntps_pkg::CSR_WANTED_TYPE;
      csr_write_data   <= noisy;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      cur_qx     = qx;
      cur_qy     = qy;
      cur_filter = filt;
      cur_kind   = kind;
      settings_used++;
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_words != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic pick_query_setting();
      logic signed [ntps_pkg::PORT_COORD_W-1:0] qx;
      logic signed [ntps_pkg::PORT_COORD_W-1:0] qy;
      case ($urandom_range(3))
         0:       qx = 16'sh8000;
         1:       qx = 16'sh7FFF;
         default: qx = 16'($urandom);
      endcase
      case ($urandom_range(3))
         0:       qy = 16'sh7FFF;
         1:       qy = 16'sh8000;
         default: qy = 16'($urandom);
      endcase
      program_query(qx, qy, 1'($urandom_range(1)), 3'($urandom_range(7)));
   endtask

   task automatic offer_random_place(input logic last);
      logic        [ntps_pkg::ID_W-1:0]         id;
      logic signed [ntps_pkg::PORT_COORD_W-1:0] px;
      logic signed [ntps_pkg::PORT_COORD_W-1:0] py;
      logic        [ntps_pkg::KIND_W-1:0]       kind;
      case ($urandom_range(15))
         0:       id = '0;
         1:       id = '1;
         default: id = $urandom;
      endcase
      // mostly near the query, small offsets give many equal distances
      case ($urandom_range(3))
         0: begin
            px = 16'($urandom);
            py = 16'($urandom);
         end
         3: begin
            px = cur_qx + 16'(int'($urandom_range(600)) - 300);
            py = cur_qy + 16'(int'($urandom_range(600)) - 300);
         end
         default: begin
            px = cur_qx + 16'(int'($urandom_range(6)) - 3);
            py = cur_qy + 16'(int'($urandom_range(6)) - 3);
         end
      endcase
      if (cur_filter && $urandom_range(9) < 7)
         kind = cur_kind;
      else
         kind = 3'($urandom_range(7));
      offer_place(id, px, py, kind, last);
   endtask

   task automatic run_queries(input int quota);
      int start;
      int len;
      start = places_sent;
      while (places_sent - start < quota) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 1);
         for (int k = 0; k < len; k++) offer_random_place(k == len - 1);
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 63;

      // directed: field extremes, ties, filtering, empty query
      program_query(16'sd0, 16'sd0, 1'b0, 3'd0);
      offer_place(32'hFFFF_FFFF, 16'sh7FFF, 16'sh8000, 3'd7, 1'b1);
      offer_place(32'd1,  16'sd3,  16'sd4,  3'd0, 1'b0);
      offer_place(32'd2, -16'sd4,  16'sd3,  3'd1, 1'b0);
      offer_place(32'd3,  16'sd0, -16'sd5,  3'd2, 1'b0);
      offer_place(32'd4,  16'sd5,  16'sd0,  3'd3, 1'b0);  // equal: no replace
      offer_place(32'd5,  16'sd1,  16'sd1,  3'd4, 1'b0);  // smaller: replaces worst
      offer_place(32'd6,  16'sh8000, 16'sh8000, 3'd5, 1'b1);
      wait_until_drained();

      program_query(16'sh7FFF, 16'sh8000, 1'b1, 3'd3);
      offer_place(32'd0, 16'sh8000, 16'sh7FFF, 3'd3, 1'b0);  // largest distance
      offer_place(32'd7, 16'sd100, 16'sd100, 3'd4, 1'b0);    // filtered out
      offer_place(32'd8, 16'sh7FFF, 16'sh8000, 3'd3, 1'b0);  // zero distance
      offer_place(32'd9, 16'sd0, 16'sd0, 3'd0, 1'b1);        // filtered last
      offer_place(32'd10, 16'sd0, 16'sd0, 3'd1, 1'b1);       // nothing kept
      wait_until_drained();

      program_query(16'sh8000, 16'sh7FFF, 1'b1, 3'd0);
      offer_place(32'd11, 16'sh8000, 16'sh7FFF, 3'd0, 1'b0);
      offer_place(32'd12, 16'sh8001, 16'sh7FFE, 3'd0, 1'b0);
      offer_place(32'd13, 16'sh8002, 16'sh7FFF, 3'd0, 1'b0);
      offer_place(32'd14, 16'sh8000, 16'sh7FFD, 3'd0, 1'b0);
      offer_place(32'd15, 16'sh8001, 16'sh7FFF, 3'd0, 1'b0);
      offer_place(32'd16, 16'sd5, 16'sd5, 3'd7, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 34; recv_idle_pct = 63; end
            1: begin send_idle_pct = 63; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 2; seg++) begin
            wait_until_drained();
            pick_query_setting();
            run_queries(20);
         end
      end

      // back-pressure: receiver stalls while short queries keep coming
      wait_until_drained();
      hold_request = 1'b1;
      for (int q = 0; q < 12; q++) begin
         offer_random_place(1'b0);
         offer_random_place(1'b1);
      end

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("run covered %0d queries, %0d points (%0d qualifying), %0d result words",
               queries_sent, places_sent, points_used, words_seen);
      $display("over %0d register settings, three idle mixes and a %0d-cycle output stall",
               settings_used, HOLD_OFF_CYCLES);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
